>>> hdl/rdm_rx_pkg.sv
// -----------------------------------------------------------------------------
// rdm_rx_pkg
// Shared types and constants for the RDM request receiver.
// -----------------------------------------------------------------------------
package rdm_rx_pkg;

   localparam logic [7:0] START_CODE         = 8'hCC;
   localparam logic [7:0] SUB_START_CODE     = 8'h01;
   localparam logic [7:0] MIN_MESSAGE_LENGTH = 8'd24;
   localparam logic [7:0] MAX_PARAM_BYTES    = 8'd231;
   localparam logic [8:0] POS_MAX            = 9'd511;
   localparam logic [8:0] POS_LAST_SHORT     = 9'd25;
   localparam logic [8:0] POS_FIRST_DATA     = 9'd24;
   localparam logic [8:0] POS_FIRST_HEADER   = 9'd15;
   localparam int         HEADER_BYTES       = 9;

   // register indexes (byte address 8*i)
   localparam logic REG_OWN_UID = 1'b0;
   localparam logic REG_MFR_ID  = 1'b1;

   // result word kinds
   localparam logic KIND_DATA    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // frame status codes
   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_SHORT     = 3'd1;
   localparam logic [2:0] STATUS_START     = 3'd2;
   localparam logic [2:0] STATUS_SUBSTART  = 3'd3;
   localparam logic [2:0] STATUS_LENGTH    = 3'd4;
   localparam logic [2:0] STATUS_NOT_ADDR  = 3'd5;
   localparam logic [2:0] STATUS_CHECKSUM  = 3'd6;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       end_of_frame;
   } req_word_type;

   typedef struct packed {
      logic        item_kind;
      logic [7:0]  data_value;
      logic [7:0]  data_offset;
      logic [47:0] source_uid;
      logic [7:0]  transaction_num;
      logic [7:0]  port_or_response;
      logic [7:0]  queued_messages;
      logic [15:0] subdevice_num;
      logic [7:0]  command_class;
      logic [15:0] parameter_id;
      logic [7:0]  data_length;
      logic [2:0]  frame_status;
   } rsp_word_type;

endpackage

>>> hdl/rdm_request_receiver_top.sv
// -----------------------------------------------------------------------------
// rdm_request_receiver_top
// RDM request frame parser: checks codes, length, destination and checksum,
// emits parameter data bytes and one summary word per frame.
// -----------------------------------------------------------------------------
// latency: a result word is valid in the cycle after its input byte is taken
// throughput: one byte per cycle while rsp_ready holds; the output register
//   frees itself in the same cycle it is drained, so bytes stream without gaps
// reset: synchronous, clears frame state, registers and the output valid flag
// frame state is also cleared after every byte marked end of frame
module rdm_request_receiver_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  rdm_rx_pkg::req_word_type    req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output rdm_rx_pkg::rsp_word_type    rsp_data,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [3:0]                  csr_paddr,
   input  logic [63:0]                 csr_pwdata,
   output logic [63:0]                 csr_prdata,
   output logic                        csr_pready
);
   import rdm_rx_pkg::*;

   // configuration
   logic [47:0] own_uid_ff;
   logic [15:0] mfr_id_ff;
   logic        csr_write;

   // frame state
   logic [8:0]  pos_ff, pos_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  msg_len_ff, msg_len_in;
   logic [47:0] dest_ff, dest_in;
   logic [47:0] src_ff, src_in;
   logic [7:0]  hdr_ff [HEADER_BYTES];
   logic [7:0]  hdr_in [HEADER_BYTES];
   logic [15:0] rx_sum_ff, rx_sum_in;
   logic [1:0]  code_err_ff, code_err_in;

   // output register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_data_ff, rsp_data_in;

   logic       req_fire;
   logic [7:0] b;
   logic       addressed;
   logic       emit_data;
   logic [7:0] data_idx;
   logic [2:0] status;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[3] == REG_MFR_ID) ? {48'd0, mfr_id_ff}
                                                    : {16'd0, own_uid_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         own_uid_ff <= '0;
         mfr_id_ff  <= '0;
      end else if (csr_write) begin
         unique case (csr_paddr[3])
            REG_OWN_UID: own_uid_ff <= csr_pwdata[47:0];
            REG_MFR_ID:  mfr_id_ff  <= csr_pwdata[15:0];
            default:     own_uid_ff <= own_uid_ff;
         endcase
      end
   end

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign b         = req_data.rx_byte;
   assign data_idx  = pos_ff[7:0] - POS_FIRST_DATA[7:0];

   // destination is settled by the time data or the summary are decided
   assign addressed = (dest_ff == own_uid_ff) || (dest_ff == {48{1'b1}}) ||
                      (dest_ff == {mfr_id_ff, 32'hFFFF_FFFF});

   // per-byte state update
   always_comb begin
      code_err_in = code_err_ff;
      msg_len_in  = msg_len_ff;
      sum_in      = sum_ff;
      dest_in     = dest_ff;
      src_in      = src_ff;
      rx_sum_in   = rx_sum_ff;
      for (int k = 0; k < HEADER_BYTES; k++) begin
         hdr_in[k] = hdr_ff[k];
         if (pos_ff == POS_FIRST_HEADER + 9'(k)) hdr_in[k] = b;
      end
      if (pos_ff == 9'd0 && b != START_CODE)     code_err_in[0] = 1'b1;
      if (pos_ff == 9'd1 && b != SUB_START_CODE) code_err_in[1] = 1'b1;
      if (pos_ff == 9'd2) msg_len_in = b;
      if (pos_ff < 9'd3 || pos_ff < {1'b0, msg_len_ff}) sum_in = sum_ff + {8'd0, b};
      if (pos_ff >= 9'd3 && pos_ff <= 9'd8)  dest_in = {dest_ff[39:0], b};
      if (pos_ff >= 9'd9 && pos_ff <= 9'd14) src_in  = {src_ff[39:0], b};
      if (pos_ff >= 9'd3 && pos_ff == {1'b0, msg_len_ff})
         rx_sum_in[15:8] = b;
      if (pos_ff >= 9'd3 && pos_ff == {1'b0, msg_len_ff} + 9'd1)
         rx_sum_in[7:0] = b;
      pos_in = (pos_ff < POS_MAX) ? pos_ff + 9'd1 : pos_ff;
   end

   assign emit_data = (pos_ff >= POS_FIRST_DATA) && (pos_ff < {1'b0, msg_len_ff}) &&
                      (code_err_ff == 2'b00) && addressed &&
                      (data_idx < hdr_ff[8]) && (data_idx < MAX_PARAM_BYTES);

   // status priority: short, start, sub-start, length, address, checksum
   always_comb begin
      if (pos_ff < POS_LAST_SHORT)
         status = STATUS_SHORT;
      else if (code_err_in[0])
         status = STATUS_START;
      else if (code_err_in[1])
         status = STATUS_SUBSTART;
      else if (msg_len_in < MIN_MESSAGE_LENGTH || {1'b0, msg_len_in} > pos_ff - 9'd1)
         status = STATUS_LENGTH;
      else if (!addressed)
         status = STATUS_NOT_ADDR;
      else if (rx_sum_in != sum_in)
         status = STATUS_CHECKSUM;
      else
         status = STATUS_OK;
   end

   always_comb begin
      rsp_data_in = '0;
      if (req_data.end_of_frame) begin
         rsp_data_in.item_kind        = KIND_SUMMARY;
         rsp_data_in.source_uid       = src_in;
         rsp_data_in.transaction_num  = hdr_in[0];
         rsp_data_in.port_or_response = hdr_in[1];
         rsp_data_in.queued_messages  = hdr_in[2];
         rsp_data_in.subdevice_num    = {hdr_in[3], hdr_in[4]};
         rsp_data_in.command_class    = hdr_in[5];
         rsp_data_in.parameter_id     = {hdr_in[6], hdr_in[7]};
         rsp_data_in.data_length      = hdr_in[8];
         rsp_data_in.frame_status     = status;
      end else begin
         rsp_data_in.item_kind   = KIND_DATA;
         rsp_data_in.data_value  = b;
         rsp_data_in.data_offset = data_idx;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (req_fire) rsp_valid_in = req_data.end_of_frame || emit_data;
   end

   always_ff @(posedge clock) begin
      if (reset || (req_fire && req_data.end_of_frame)) begin
         pos_ff      <= '0;
         sum_ff      <= '0;
         msg_len_ff  <= '0;
         dest_ff     <= '0;
         src_ff      <= '0;
         rx_sum_ff   <= '0;
         code_err_ff <= '0;
         for (int k = 0; k < HEADER_BYTES; k++) hdr_ff[k] <= '0;
      end else if (req_fire) begin
         pos_ff      <= pos_in;
         sum_ff      <= sum_in;
         msg_len_ff  <= msg_len_in;
         dest_ff     <= dest_in;
         src_ff      <= src_in;
         rx_sum_ff   <= rx_sum_in;
         code_err_ff <= code_err_in;
         for (int k = 0; k < HEADER_BYTES; k++) hdr_ff[k] <= hdr_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_frame_end_clears: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_data.end_of_frame |=> pos_ff == 9'd0 && code_err_ff == 2'b00)
      else $error("frame state not cleared after end of frame");

   a_offset_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.item_kind == KIND_DATA |->
         rsp_data.data_offset < MAX_PARAM_BYTES)
      else $error("data offset beyond parameter data limit");

   a_summary_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.item_kind == KIND_SUMMARY |->
         rsp_data.data_value == 8'd0 && rsp_data.data_offset == 8'd0)
      else $error("summary word carries data fields");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("input stalled with empty output register");

endmodule
